>>> sv/kpd_pkg.sv
// Shared constants, types and key-code table for the keypad press detector.
package kpd_pkg;

  localparam int unsigned NUM_KEYS_DEF   = 4;
  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned MAX_KEYS       = 16;
  localparam int unsigned REG_W          = 32;
  localparam int unsigned CFG_IDX_W      = 8;
  localparam int unsigned LEVEL_W        = 4;
  localparam int unsigned CODE_W         = 8;
  localparam int unsigned KIND_W         = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEB_ENABLE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK = 8'd3;

  // Reset values of the configuration registers
  localparam logic [REG_W-1:0]   LONG_PRESS_RST  = 32'd1000;
  localparam logic [REG_W-1:0]   DEBOUNCE_RST    = 32'd20;
  localparam logic               DEB_ENABLE_RST  = 1'b0;
  localparam logic [LEVEL_W-1:0] ACTIVE_MASK_RST = 4'd0;

  // Per-key phase codes
  localparam logic [1:0] PH_RELEASED = 2'd0;
  localparam logic [1:0] PH_PREPRESS = 2'd1;
  localparam logic [1:0] PH_PRESSED  = 2'd2;
  localparam logic [1:0] PH_LONG     = 2'd3;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_PRESSED  = 2'd0;
  localparam logic [KIND_W-1:0] EV_RELEASED = 2'd1;
  localparam logic [KIND_W-1:0] EV_LONG     = 2'd2;

  // Key codes
  localparam logic [CODE_W-1:0] CODE_KEY0 = 8'hB1;
  localparam logic [CODE_W-1:0] CODE_KEY1 = 8'hB0;
  localparam logic [CODE_W-1:0] CODE_KEY2 = 8'hD8;
  localparam logic [CODE_W-1:0] CODE_KEY3 = 8'hD7;
  localparam logic [CODE_W-1:0] CODE_NONE = 8'h00;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
  } kpd_event_t;

  function automatic logic [CODE_W-1:0] key_code(input logic [3:0] idx);
    logic [CODE_W-1:0] code;
    case (idx)
      4'd0:    code = CODE_KEY0;
      4'd1:    code = CODE_KEY1;
      4'd2:    code = CODE_KEY2;
      4'd3:    code = CODE_KEY3;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

endpackage

>>> sv/kpd_key_lane.sv
// One key lane: phase state machine and time stamp for a single key.
module kpd_key_lane #(
  parameter int unsigned TIME_WIDTH = kpd_pkg::TIME_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic                     down_i,
  input  logic [TIME_WIDTH-1:0]    now_i,
  input  logic                     deb_en_i,
  input  logic [kpd_pkg::REG_W-1:0] debounce_i,
  input  logic [kpd_pkg::REG_W-1:0] long_press_i,
  output kpd_pkg::kpd_event_t      event_o
);

  localparam int unsigned CMP_W = (TIME_WIDTH > kpd_pkg::REG_W) ? TIME_WIDTH : kpd_pkg::REG_W;

  logic [1:0]            phase_q, phase_d;
  logic [TIME_WIDTH-1:0] stamp_q, stamp_d;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  past_debounce;
  logic                  past_long;

  // Elapsed time wraps modulo 2^TIME_WIDTH
  assign elapsed       = now_i - stamp_q;
  assign past_debounce = CMP_W'(elapsed) > CMP_W'(debounce_i);
  assign past_long     = CMP_W'(elapsed) > CMP_W'(long_press_i);

  always_comb begin
    phase_d       = phase_q;
    stamp_d       = stamp_q;
    event_o.valid = 1'b0;
    event_o.kind  = kpd_pkg::EV_PRESSED;
    case (phase_q)
      kpd_pkg::PH_RELEASED: begin
        if (down_i) begin
          stamp_d = now_i;
          if (deb_en_i) begin
            phase_d = kpd_pkg::PH_PREPRESS;
          end else begin
            phase_d       = kpd_pkg::PH_PRESSED;
            event_o.valid = 1'b1;
            event_o.kind  = kpd_pkg::EV_PRESSED;
          end
        end
      end
      kpd_pkg::PH_PREPRESS: begin
        if (down_i) begin
          if (past_debounce) begin
            phase_d       = kpd_pkg::PH_PRESSED;
            stamp_d       = now_i;
            event_o.valid = 1'b1;
            event_o.kind  = kpd_pkg::EV_PRESSED;
          end
        end else begin
          phase_d = kpd_pkg::PH_RELEASED;
        end
      end
      default: begin
        if (!down_i) begin
          phase_d       = kpd_pkg::PH_RELEASED;
          stamp_d       = '0;
          event_o.valid = 1'b1;
          event_o.kind  = kpd_pkg::EV_RELEASED;
        end else if (phase_q == kpd_pkg::PH_PRESSED && past_long) begin
          phase_d       = kpd_pkg::PH_LONG;
          stamp_d       = now_i;
          event_o.valid = 1'b1;
          event_o.kind  = kpd_pkg::EV_LONG;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kpd_pkg::PH_RELEASED;
      stamp_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      stamp_q <= stamp_d;
    end
  end

endmodule

>>> sv/kpd_event_merge.sv
// Merge stage: holds one poll's lane events and sends them out in key order.
module kpd_event_merge #(
  parameter int unsigned NUM_KEYS = kpd_pkg::NUM_KEYS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  kpd_pkg::kpd_event_t [NUM_KEYS-1:0]  events_i,
  output logic                                ready_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [kpd_pkg::CODE_W-1:0]          key_code_o,
  output logic [kpd_pkg::KIND_W-1:0]          event_kind_o,
  output logic                                last_event_o
);

  localparam int unsigned KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [NUM_KEYS-1:0]       pend_q, pend_d;
  logic [kpd_pkg::KIND_W-1:0] kind_q [NUM_KEYS];
  logic [NUM_KEYS-1:0]       rest;
  logic [KIW-1:0]            idx;
  logic                      pend_any;
  logic                      out_free;
  logic                      move;

  logic                       out_valid_q, out_valid_d;
  logic [kpd_pkg::CODE_W-1:0] code_q;
  logic [kpd_pkg::KIND_W-1:0] okind_q;
  logic                       last_q;

  // Lowest pending key goes first
  always_comb begin
    idx = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        idx = KIW'(i);
      end
    end
  end

  always_comb begin
    rest      = pend_q;
    rest[idx] = 1'b0;
  end

  assign pend_any = |pend_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign move     = out_free && pend_any;
  assign ready_o  = !pend_any || (move && (rest == '0));

  always_comb begin
    pend_d = pend_q;
    if (load_i) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        pend_d[i] = events_i[i].valid;
      end
    end else if (move) begin
      pend_d = rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        kind_q[i] <= events_i[i].kind;
      end
    end
    if (move) begin
      code_q  <= kpd_pkg::key_code(4'(idx));
      okind_q <= kind_q[idx];
      last_q  <= (rest == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_code_o   = code_q;
  assign event_kind_o = okind_q;
  assign last_event_o = last_q;

endmodule

>>> sv/keypad_press_long_press_detector_core.sv
// Top level of the keypad press / long-press detector.
//
// Usage:
//   Poll channel (in_valid_i / in_stall_o): one item per poll with the raw
//   key levels and the current millisecond time. Each key has its own lane
//   that updates its phase and time stamp at the edge the item is accepted.
//   Event channel (out_valid_o / out_stall_i): one item per event, with the
//   key code, the kind (pressed, released, long pressed) and a flag on the
//   last event of a poll. Events leave in key order.
//   Flow: a poll's events wait in the merge stage's pending register and
//   move one at a time into its single event register, which bounds rate.
//   A poll with several events holds the merge stage until the last moves;
//   one with no event or one event lets the next poll in on the following
//   cycle unless the receiver stalls, so polls may arrive back to back.
//   Stall: while the receiver stalls, the shown event holds; pending events
//   wait in the merge stage and in_stall_o rises until the last one moves.
//   Configuration: plain write port, to be written only while idle; the block does not enforce it.
//   Reset: all keys released, stamps zero, registers at their defaults.
module keypad_press_long_press_detector_core #(
  parameter int unsigned NUM_KEYS   = kpd_pkg::NUM_KEYS_DEF,
  parameter int unsigned TIME_WIDTH = kpd_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [kpd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kpd_pkg::REG_W-1:0]     cfg_wdata_i,
  // poll items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kpd_pkg::LEVEL_W-1:0]   key_levels_i,
  input  logic [31:0]                   now_ms_i,
  // event items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kpd_pkg::CODE_W-1:0]    key_code_o,
  output logic [kpd_pkg::KIND_W-1:0]    event_kind_o,
  output logic                          last_event_o
);

  logic [kpd_pkg::REG_W-1:0]   long_press_q;
  logic [kpd_pkg::REG_W-1:0]   debounce_q;
  logic                        deb_en_q;
  logic [kpd_pkg::LEVEL_W-1:0] mask_q;

  logic                                in_accept;
  logic                                merge_ready;
  logic [TIME_WIDTH-1:0]               now_t;
  kpd_pkg::kpd_event_t [NUM_KEYS-1:0]  lane_events;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= kpd_pkg::LONG_PRESS_RST;
      debounce_q   <= kpd_pkg::DEBOUNCE_RST;
      deb_en_q     <= kpd_pkg::DEB_ENABLE_RST;
      mask_q       <= kpd_pkg::ACTIVE_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kpd_pkg::REG_LONG_PRESS:  long_press_q <= cfg_wdata_i;
        kpd_pkg::REG_DEBOUNCE:    debounce_q   <= cfg_wdata_i;
        kpd_pkg::REG_DEB_ENABLE:  deb_en_q     <= cfg_wdata_i[0];
        kpd_pkg::REG_ACTIVE_MASK: mask_q       <= cfg_wdata_i[kpd_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a poll whenever the merge stage can hold its events
  assign in_stall_o = !merge_ready;
  assign in_accept  = in_valid_i && !merge_ready ? 1'b0 : in_valid_i;
  assign now_t      = TIME_WIDTH'(now_ms_i);

  // One lane per key. Keys past the level field are tied down, so they
  // always count as held down.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic down;
    if (k < kpd_pkg::LEVEL_W) begin : g_real
      assign down = (key_levels_i[k] == mask_q[k]);
    end else begin : g_extra
      assign down = 1'b1;
    end

    kpd_key_lane #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .accept_i     (in_accept),
      .down_i       (down),
      .now_i        (now_t),
      .deb_en_i     (deb_en_q),
      .debounce_i   (debounce_q),
      .long_press_i (long_press_q),
      .event_o      (lane_events[k])
    );
  end

  // Collect the lanes' events and emit them one per cycle while the receiver does not stall
  kpd_event_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_accept),
    .events_i     (lane_events),
    .ready_o      (merge_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_code_o   (key_code_o),
    .event_kind_o (event_kind_o),
    .last_event_o (last_event_o)
  );

  // A non-last event that is taken is always followed by the next one
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_event_o |=> out_valid_o)
    else $error("event burst broken before its last event");

  // While a non-last event waits on a stall, no new poll may enter
  a_no_poll_mid_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && !last_event_o |-> in_stall_o)
    else $error("poll accepted while events of the previous poll are pending");

  // With only coded keys, every event carries a nonzero code
  a_code_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (NUM_KEYS <= kpd_pkg::LEVEL_W) |-> key_code_o != kpd_pkg::CODE_NONE)
    else $error("event with empty key code");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the keypad press / long-press detector core.
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE_TAIL  = 8;        // leave margin after the last owed event
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_KEYS     = 4;
  localparam int IDX_W        = kpd_pkg::CFG_IDX_W;

  typedef struct packed {
    logic [kpd_pkg::CODE_W-1:0] code;
    logic [kpd_pkg::KIND_W-1:0] kind;
    logic                       last;
  } key_event_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          cfg_we_i     = 1'b0;
  logic [kpd_pkg::CFG_IDX_W-1:0] cfg_index_i  = kpd_pkg::REG_LONG_PRESS;
  logic [kpd_pkg::REG_W-1:0]     cfg_wdata_i  = '0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_stall_o;
  logic [kpd_pkg::LEVEL_W-1:0]   key_levels_i = '0;
  logic [31:0]                   now_ms_i     = '0;
  logic                          out_valid_o;
  logic                          out_stall_i  = 1'b0;
  logic [kpd_pkg::CODE_W-1:0]    key_code_o;
  logic [kpd_pkg::KIND_W-1:0]    event_kind_o;
  logic                          last_event_o;

  // Predictor state: per-key phase and time stamp, plus a shadow of the registers.
  logic [1:0]                 key_phase_q [NUM_KEYS];
  logic [31:0]                key_stamp_q [NUM_KEYS];
  logic [kpd_pkg::CODE_W-1:0] key_code_tab [NUM_KEYS];
  logic [31:0]                cfg_long_ms;
  logic [31:0]                cfg_deb_ms;
  logic                       cfg_deb_en;
  logic [3:0]                 cfg_active_mask;

  key_event_t pending_events [$];   // events the block still owes, oldest first
  key_event_t exp_event;

  int         error_count     = 0;
  int         cycle_count     = 0;
  bit         src_idle_en     = 1'b0;
  bit         sink_idle_en    = 1'b0;
  int         hold_req_cycles = 0;
  int         hold_len;
  logic [3:0] levels_now      = '0;
  logic [31:0] clock_ms       = '0;

  keypad_press_long_press_detector_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .key_levels_i (key_levels_i),
    .now_ms_i     (now_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_code_o   (key_code_o),
    .event_kind_o (event_kind_o),
    .last_event_o (last_event_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Load the power-on state: all keys released, stamps zero, registers at default.
  function automatic void reset_key_model();
    for (int i = 0; i < NUM_KEYS; i++) begin
      key_phase_q[i] = kpd_pkg::PH_RELEASED;
      key_stamp_q[i] = '0;
    end
    key_code_tab[0] = kpd_pkg::CODE_KEY0;
    key_code_tab[1] = kpd_pkg::CODE_KEY1;
    key_code_tab[2] = kpd_pkg::CODE_KEY2;
    key_code_tab[3] = kpd_pkg::CODE_KEY3;
    cfg_long_ms     = kpd_pkg::LONG_PRESS_RST;
    cfg_deb_ms      = kpd_pkg::DEBOUNCE_RST;
    cfg_deb_en      = kpd_pkg::DEB_ENABLE_RST;
    cfg_active_mask = kpd_pkg::ACTIVE_MASK_RST;
  endfunction

  // Mirror one register write; narrow registers keep only their low bits and
  // an unknown index changes nothing.
  function automatic void apply_reg_write(input logic [kpd_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [kpd_pkg::REG_W-1:0] data);
    case (idx)
      kpd_pkg::REG_LONG_PRESS:  cfg_long_ms     = data;
      kpd_pkg::REG_DEBOUNCE:    cfg_deb_ms      = data;
      kpd_pkg::REG_DEB_ENABLE:  cfg_deb_en      = data[0];
      kpd_pkg::REG_ACTIVE_MASK: cfg_active_mask = data[3:0];
      default: ;
    endcase
  endfunction

  // Advance every key by one poll and queue the events it raises, in key order,
  // flagging the final one of the poll.
  function automatic void predict_key_events(input logic [3:0] lv, input logic [31:0] t);
    key_event_t poll_events [$];
    key_event_t ev;
    logic       down;
    logic       fire;
    logic [kpd_pkg::KIND_W-1:0] kind;
    logic [31:0] elapsed;
    for (int i = 0; i < NUM_KEYS; i++) begin
      down    = (lv[i] == cfg_active_mask[i]);
      elapsed = t - key_stamp_q[i];   // wraps modulo 2^32
      fire    = 1'b0;
      kind    = kpd_pkg::EV_PRESSED;
      case (key_phase_q[i])
        kpd_pkg::PH_RELEASED: begin
          if (down) begin
            key_stamp_q[i] = t;
            if (cfg_deb_en) begin
              key_phase_q[i] = kpd_pkg::PH_PREPRESS;
            end else begin
              key_phase_q[i] = kpd_pkg::PH_PRESSED;
              fire = 1'b1;
              kind = kpd_pkg::EV_PRESSED;
            end
          end
        end
        kpd_pkg::PH_PREPRESS: begin
          // Finish through the pre-press rules even if debounce was turned off.
          if (down) begin
            if (elapsed > cfg_deb_ms) begin
              key_phase_q[i] = kpd_pkg::PH_PRESSED;
              key_stamp_q[i] = t;
              fire = 1'b1;
              kind = kpd_pkg::EV_PRESSED;
            end
          end else begin
            key_phase_q[i] = kpd_pkg::PH_RELEASED;   // stamp kept
          end
        end
        default: begin
          if (!down) begin
            key_phase_q[i] = kpd_pkg::PH_RELEASED;
            key_stamp_q[i] = '0;
            fire = 1'b1;
            kind = kpd_pkg::EV_RELEASED;
          end else if (key_phase_q[i] == kpd_pkg::PH_PRESSED && elapsed > cfg_long_ms) begin
            key_phase_q[i] = kpd_pkg::PH_LONG;
            key_stamp_q[i] = t;
            fire = 1'b1;
            kind = kpd_pkg::EV_LONG;
          end
        end
      endcase
      if (fire) begin
        ev.code = key_code_tab[i];
        ev.kind = kind;
        ev.last = 1'b0;
        poll_events.push_back(ev);
      end
    end
    if (poll_events.size() > 0) begin
      poll_events[poll_events.size() - 1].last = 1'b1;
    end
    foreach (poll_events[k]) pending_events.push_back(poll_events[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample handshakes at the edge, predict first, then check.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) apply_reg_write(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) predict_key_events(key_levels_i, now_ms_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          $error("unexpected event item: key_code %h event_kind %0d last_event %0d",
                 key_code_o, event_kind_o, last_event_o);
          error_count++;
        end else begin
          exp_event = pending_events.pop_front();
          if (key_code_o !== exp_event.code) begin
            $error("key_code: expected %h, got %h", exp_event.code, key_code_o);
            error_count++;
          end
          if (event_kind_o !== exp_event.kind) begin
            $error("event_kind: expected %0d, got %0d", exp_event.kind, event_kind_o);
            error_count++;
          end
          if (last_event_o !== exp_event.last) begin
            $error("last_event: expected %0d, got %0d", exp_event.last, last_event_o);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: honor a requested long hold-off first, otherwise stall in random
  // bursts while sink idling is on.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req_cycles > 0) begin
        hold_len        = hold_req_cycles;
        hold_req_cycles = 0;
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Offer one poll item and hold it until accepted; then maybe drop valid for a
  // random gap. Valid stays high when the next poll follows at once.
  task automatic send_poll(input logic [3:0] lv, input logic [31:0] t);
    int gap;
    in_valid_i   <= 1'b1;
    key_levels_i <= lv;
    now_ms_i     <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every owed event has left the block, plus the
  // latency of a poll that raises nothing. The first edge lets the monitor
  // queue the events of a poll taken at the current edge.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TAIL) @(posedge clk_i);
  endtask

  // Write one register; call only while the block is idle.
  task automatic write_reg(input logic [kpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kpd_pkg::REG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pick a threshold: mostly small so that events are frequent, with extremes.
  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  // Advance the poll time: mostly short steps, sometimes none, a full random
  // jump, or a step just behind the last time so the elapsed value wraps.
  function automatic logic [31:0] next_time();
    case ($urandom_range(0, 9))
      7:       return clock_ms;
      8:       return clock_ms + $urandom;
      9:       return clock_ms - $urandom_range(1, 4);
      default: return clock_ms + $urandom_range(0, 40);
    endcase
  endfunction

  // Mostly toggle a few keys from the current levels; sometimes throw in noise.
  function automatic logic [3:0] next_levels();
    logic [3:0] flip;
    if ($urandom_range(0, 6) == 0) return 4'($urandom);
    for (int i = 0; i < NUM_KEYS; i++) flip[i] = ($urandom_range(0, 2) == 0);
    return levels_now ^ flip;
  endfunction

  task automatic send_random_polls(input int count);
    for (int n = 0; n < count; n++) begin
      levels_now = next_levels();
      clock_ms   = next_time();
      send_poll(levels_now, clock_ms);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Defaults after reset: active-low keys, no debounce, long press beyond 1000 ms.
  task automatic test_reset_defaults();
    send_poll(4'hF, 32'd100);        // all up: nothing
    send_poll(4'h0, 32'd200);        // all down: four presses
    send_poll(4'h0, 32'd1200);       // exactly at the limit: nothing
    send_poll(4'h0, 32'd1201);       // beyond: four long presses
    send_poll(4'b0101, 32'd1300);    // release keys 0 and 2
    send_poll(4'hF, 32'd1400);       // release the rest
    settle();
  endtask

  // Long-press limit at both ends, active-high keys, and an unused index.
  task automatic test_register_extremes();
    write_reg(kpd_pkg::REG_LONG_PRESS, 32'h0000_0000);
    write_reg(kpd_pkg::REG_ACTIVE_MASK, 32'hABCD_EFFF);
    write_reg(kpd_pkg::REG_ACTIVE_MASK + 8'd1, 32'h0000_0000);   // must be ignored
    write_reg({kpd_pkg::CFG_IDX_W{1'b1}}, 32'hFFFF_FFFF);        // must be ignored
    send_poll(4'hF, 32'd0);          // press all
    send_poll(4'hF, 32'd0);          // no time passed: nothing
    send_poll(4'hF, 32'd1);          // limit zero: long press on all
    send_poll(4'h0, 32'd2);          // release all
    settle();
    write_reg(kpd_pkg::REG_LONG_PRESS, 32'hFFFF_FFFF);
    send_poll(4'h3, 32'h8000_0000);
    send_poll(4'h3, 32'h7FFF_FFFF);  // largest elapsed value never exceeds the limit
    send_poll(4'h0, 32'h7FFF_FFFF);
    settle();
  endtask

  // Debounce path: pre-press hold, release from pre-press, debounce switched off
  // while keys sit in pre-press, and the debounce limit at both ends.
  task automatic test_debounce_path();
    write_reg(kpd_pkg::REG_DEB_ENABLE, 32'hFFFF_FFFE);   // bit 0 low: still off
    write_reg(kpd_pkg::REG_DEB_ENABLE, 32'h0000_0001);
    write_reg(kpd_pkg::REG_DEBOUNCE, 32'd5);
    write_reg(kpd_pkg::REG_LONG_PRESS, 32'd10);
    send_poll(4'hF, 32'd1000);       // all into pre-press, silent
    send_poll(4'hF, 32'd1005);       // not beyond debounce yet
    send_poll(4'b0011, 32'd1006);    // keys 0, 1 pressed; keys 2, 3 drop back silently
    send_poll(4'hC, 32'd1010);       // keys 0, 1 released; keys 2, 3 into pre-press
    settle();
    write_reg(kpd_pkg::REG_DEB_ENABLE, 32'h0000_0000);
    send_poll(4'hC, 32'd1020);       // pre-press keys still finish by the debounce rule
    send_poll(4'h0, 32'd1030);
    settle();
    write_reg(kpd_pkg::REG_DEB_ENABLE, 32'h0000_0001);
    write_reg(kpd_pkg::REG_DEBOUNCE, 32'hFFFF_FFFF);
    send_poll(4'h1, 32'd1040);
    send_poll(4'h1, 32'd1039);       // maximal elapsed value, still held in pre-press
    settle();
    write_reg(kpd_pkg::REG_DEBOUNCE, 32'h0000_0000);
    send_poll(4'h1, 32'd1040);       // elapsed zero: not beyond
    send_poll(4'h1, 32'd1041);       // beyond zero: pressed
    settle();
  endtask

  // Stamps near the top of the time range, compared across the wrap.
  task automatic test_time_wrap();
    write_reg(kpd_pkg::REG_DEB_ENABLE, 32'h0000_0000);
    write_reg(kpd_pkg::REG_LONG_PRESS, 32'h0000_0020);
    send_poll(4'h8, 32'hFFFF_FFF0);  // key 0 released, key 3 pressed
    send_poll(4'h8, 32'h0000_0010);  // elapsed 0x20: not beyond
    send_poll(4'h8, 32'h0000_0011);  // beyond: key 3 long press
    send_poll(4'h0, 32'h0000_0012);
    settle();
    levels_now = 4'h0;
    clock_ms   = 32'h0000_0012;
  endtask

  // Random phases, each with a fresh register setting and its own idling mix.
  task automatic test_random_phases(input int phases, input int polls_per_phase);
    for (int p = 0; p < phases; p++) begin
      settle();
      write_reg(kpd_pkg::REG_LONG_PRESS, pick_threshold());
      write_reg(kpd_pkg::REG_DEBOUNCE, pick_threshold());
      write_reg(kpd_pkg::REG_DEB_ENABLE, $urandom);
      write_reg(kpd_pkg::REG_ACTIVE_MASK, $urandom);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(IDX_W'($urandom_range(kpd_pkg::REG_ACTIVE_MASK + 1,
                                        (1 << kpd_pkg::CFG_IDX_W) - 1)), $urandom);
      end
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      send_random_polls(polls_per_phase);
    end
    settle();
  endtask

  // Hold the receiver off while polls that each raise four events keep coming,
  // so the block fills and stalls its input; then pause until all has drained.
  task automatic test_backpressure();
    write_reg(kpd_pkg::REG_ACTIVE_MASK, 32'h0000_0000);
    write_reg(kpd_pkg::REG_DEB_ENABLE, 32'h0000_0000);
    write_reg(kpd_pkg::REG_LONG_PRESS, 32'hFFFF_FFFF);
    src_idle_en     = 1'b0;
    sink_idle_en    = 1'b0;
    hold_req_cycles = HOLD_CYCLES;
    for (int n = 0; n < 24; n++) begin
      clock_ms = clock_ms + 1;
      send_poll((n % 2) ? 4'hF : 4'h0, clock_ms);
    end
    // Pause the sender until every owed event has arrived.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    sink_idle_en = 1'b1;
    for (int n = 0; n < 8; n++) begin
      clock_ms = clock_ms + 1;
      send_poll((n % 2) ? 4'hF : 4'h0, clock_ms);
    end
    settle();
    levels_now = 4'hF;
  endtask

  // Closing stretch: no idling on either side, polls back to back.
  task automatic test_no_idle_tail();
    write_reg(kpd_pkg::REG_LONG_PRESS, $urandom_range(1, 20));
    write_reg(kpd_pkg::REG_DEBOUNCE, $urandom_range(0, 10));
    write_reg(kpd_pkg::REG_DEB_ENABLE, $urandom);
    write_reg(kpd_pkg::REG_ACTIVE_MASK, $urandom);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    send_random_polls(30);
    settle();
  endtask

  initial begin
    reset_key_model();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_debounce_path();
    test_time_wrap();
    test_random_phases(9, 32);
    test_backpressure();
    test_no_idle_tail();

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
